>>> sv/bct_pkg.sv
// Shared types and codes for the box containment test.
package bct_pkg;

  localparam int unsigned MODE_WIDTH      = 2;
  localparam int unsigned CFG_INDEX_WIDTH = 3;
  localparam int unsigned AXES            = 3;

  typedef logic [MODE_WIDTH-1:0]      mode_t;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  // shape kinds; every other code is an unknown kind
  localparam mode_t MODE_SPHERE = 2'd0;
  localparam mode_t MODE_BOX    = 2'd1;

  // room bound register indexes
  localparam cfg_index_t REG_MIN_X = 3'd0;
  localparam cfg_index_t REG_MAX_X = 3'd1;
  localparam cfg_index_t REG_MIN_Y = 3'd2;
  localparam cfg_index_t REG_MAX_Y = 3'd3;
  localparam cfg_index_t REG_MIN_Z = 3'd4;
  localparam cfg_index_t REG_MAX_Z = 3'd5;

  // axis slots in the bound and extent arrays
  localparam int unsigned AXIS_X = 0;
  localparam int unsigned AXIS_Y = 1;
  localparam int unsigned AXIS_Z = 2;

  // pipeline stage load enables
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
  } stage_en_t;

endpackage

>>> sv/bct_if.sv
// Channel interfaces: shape words in, verdict words out, room bound writes.
interface bct_shape_if #(
  parameter int COORD_WIDTH = 24,
  parameter int ANGLE_BITS  = 12
);
  logic                          valid;
  logic                          ready;
  bct_pkg::mode_t                mode;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic        [COORD_WIDTH-2:0] half_x;
  logic        [COORD_WIDTH-2:0] half_y;
  logic        [COORD_WIDTH-2:0] half_z;
  logic        [ANGLE_BITS-1:0]  yaw_angle;

  modport source (
    output valid, mode, center_x, center_y, center_z, half_x, half_y, half_z, yaw_angle,
    input  ready
  );
  modport sink (
    input  valid, mode, center_x, center_y, center_z, half_x, half_y, half_z, yaw_angle,
    output ready
  );
endinterface

interface bct_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

interface bct_cfg_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  bct_pkg::cfg_index_t           index;
  logic        [COORD_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/bct_cfg_regs.sv
// Room bound registers, written through the configuration channel.
module bct_cfg_regs #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  bct_cfg_if.sink                       cfg,
  output logic signed [COORD_WIDTH-1:0] room_lo [bct_pkg::AXES],
  output logic signed [COORD_WIDTH-1:0] room_hi [bct_pkg::AXES]
);
  import bct_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        room_lo[i] <= '0;
        room_hi[i] <= '0;
      end
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MIN_X: room_lo[AXIS_X] <= cfg.data;
        REG_MAX_X: room_hi[AXIS_X] <= cfg.data;
        REG_MIN_Y: room_lo[AXIS_Y] <= cfg.data;
        REG_MAX_Y: room_hi[AXIS_Y] <= cfg.data;
        REG_MIN_Z: room_lo[AXIS_Z] <= cfg.data;
        REG_MAX_Z: room_hi[AXIS_Z] <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/bct_trig_rom.sv
// Quarter-wave sine ROM with two registered read ports.
module bct_trig_rom #(
  parameter int ANGLE_BITS = 12,
  parameter int TRIG_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic                  quad_odd,
  output logic [TRIG_WIDTH-1:0] sin_i,
  output logic [TRIG_WIDTH-1:0] sin_qi
);
  localparam int QBITS = ANGLE_BITS - 2;
  localparam int FRAC  = TRIG_WIDTH - 1;
  localparam int Q     = 1 << QBITS;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  typedef logic [TRIG_WIDTH-1:0] entry_t;
  typedef entry_t tab_t [Q+1];

  // sin(k*pi/(2Q)) in Q1.FRAC from a fixed-point Taylor series
  function automatic entry_t quarter_sine(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    longint          sum;
    x    = (64'(k) * HALF_PI_Q30 + 64'(Q / 2)) >> QBITS;
    x2   = (x * x + (ONE_Q30 >> 1)) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = (term * x2 + (ONE_Q30 >> 1)) >> 30;
      case (n)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        6:       term = term / 156;
        7:       term = term / 210;
        8:       term = term / 272;
        9:       term = term / 342;
        10:      term = term / 420;
        11:      term = term / 506;
        default: term = term / 600;
      endcase
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    s = (64'(sum) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    if (s > (64'd1 << FRAC)) begin
      s = 64'd1 << FRAC;
    end
    return entry_t'(s);
  endfunction

  function automatic tab_t build_table();
    tab_t t;
    for (int k = 0; k <= Q; k++) begin
      t[k] = quarter_sine(k);
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_table();
  localparam logic [QBITS:0] QUARTER = {1'b1, {QBITS{1'b0}}};

  logic [QBITS:0] addr_i;
  logic [QBITS:0] addr_qi;

  assign addr_i  = {1'b0, angle[QBITS-1:0]};
  assign addr_qi = QUARTER - addr_i;

  always_ff @(posedge clk) begin
    if (en) begin
      sin_i    <= SINE_TAB[addr_i];
      sin_qi   <= SINE_TAB[addr_qi];
      quad_odd <= angle[QBITS];
    end
  end

endmodule

>>> sv/bct_extent.sv
// Product and rounding stages that turn half sizes and yaw into axis extents.
module bct_extent #(
  parameter int COORD_WIDTH = 24,
  parameter int TRIG_WIDTH  = 16
) (
  input  logic                   clk,
  input  bct_pkg::stage_en_t     en,
  input  bct_pkg::mode_t         mode,
  input  logic [COORD_WIDTH-2:0] half_x,
  input  logic [COORD_WIDTH-2:0] half_y,
  input  logic [COORD_WIDTH-2:0] half_z,
  input  logic                   quad_odd,
  input  logic [TRIG_WIDTH-1:0]  sin_i,
  input  logic [TRIG_WIDTH-1:0]  sin_qi,
  output logic [COORD_WIDTH:0]   ext [bct_pkg::AXES],
  output logic                   known
);
  import bct_pkg::*;

  localparam int FRAC = TRIG_WIDTH - 1;
  localparam int PW   = COORD_WIDTH - 1 + TRIG_WIDTH;
  localparam int SW   = PW + 1;
  localparam int EW   = COORD_WIDTH + 1;
  localparam logic [SW-1:0] RND = {{(SW-1){1'b0}}, 1'b1} << (FRAC - 1);

  logic [TRIG_WIDTH-1:0] abs_sin;
  logic [TRIG_WIDTH-1:0] abs_cos;

  logic [PW-1:0]          prod_xc;
  logic [PW-1:0]          prod_zs;
  logic [PW-1:0]          prod_xs;
  logic [PW-1:0]          prod_zc;
  logic [COORD_WIDTH-2:0] hx_b;
  logic [COORD_WIDTH-2:0] hy_b;
  mode_t                  mode_b;

  logic [SW-1:0] sum_x;
  logic [SW-1:0] sum_z;
  logic [EW-1:0] ext_next [AXES];
  logic          known_next;

  assign abs_sin = quad_odd ? sin_qi : sin_i;
  assign abs_cos = quad_odd ? sin_i : sin_qi;

  always_ff @(posedge clk) begin
    if (en.b) begin
      prod_xc <= PW'(half_x) * PW'(abs_cos);
      prod_zs <= PW'(half_z) * PW'(abs_sin);
      prod_xs <= PW'(half_x) * PW'(abs_sin);
      prod_zc <= PW'(half_z) * PW'(abs_cos);
      hx_b    <= half_x;
      hy_b    <= half_y;
      mode_b  <= mode;
    end
  end

  // round each rotated sum once, half up
  assign sum_x = SW'(prod_xc) + SW'(prod_zs) + RND;
  assign sum_z = SW'(prod_xs) + SW'(prod_zc) + RND;

  always_comb begin
    ext_next[AXIS_X] = sum_x[SW-1:FRAC];
    ext_next[AXIS_Y] = EW'(hy_b);
    ext_next[AXIS_Z] = sum_z[SW-1:FRAC];
    known_next       = 1'b0;
    priority if (mode_b == MODE_SPHERE) begin
      for (int i = 0; i < AXES; i++) begin
        ext_next[i] = EW'(hx_b);
      end
      known_next = 1'b1;
    end else if (mode_b == MODE_BOX) begin
      known_next = 1'b1;
    end else begin
      known_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.c) begin
      ext   <= ext_next;
      known <= known_next;
    end
  end

endmodule

>>> sv/bct_span_check.sv
// Exact bound compare of center minus and plus extent on every axis.
module bct_span_check #(
  parameter int COORD_WIDTH = 24
) (
  input  logic signed [COORD_WIDTH-1:0] center  [bct_pkg::AXES],
  input  logic        [COORD_WIDTH:0]   ext     [bct_pkg::AXES],
  input  logic signed [COORD_WIDTH-1:0] room_lo [bct_pkg::AXES],
  input  logic signed [COORD_WIDTH-1:0] room_hi [bct_pkg::AXES],
  input  logic                          known,
  output logic                          fits
);
  import bct_pkg::*;

  localparam int XW = COORD_WIDTH + 2;

  logic signed [XW-1:0] low_edge  [AXES];
  logic signed [XW-1:0] high_edge [AXES];
  logic                 axis_ok   [AXES];

  always_comb begin
    fits = known;
    for (int i = 0; i < AXES; i++) begin
      low_edge[i]  = XW'(center[i]) - signed'(XW'(ext[i]));
      high_edge[i] = XW'(center[i]) + signed'(XW'(ext[i]));
      axis_ok[i]   = (low_edge[i] >= XW'(room_lo[i])) && (high_edge[i] <= XW'(room_hi[i]));
      fits         = fits && axis_ok[i];
    end
  end

endmodule

>>> sv/box_containment_test.sv
// Top level: shape containment test against a configurable room box.
//
//  channel  dir  word                                         handshake
//  cfg      in   index, data (room bound)                     valid/ready, ready always high
//  shape    in   mode, center_x/y/z, half_x/y/z, yaw_angle    valid/ready
//  result   out  inside_res                                   valid/ready
//
// One shape word is taken every cycle while shape.ready is high; its verdict word reaches result
// through the input/ROM stage, product stage, extent stage, and compare and result stage, in
// that order. The sine ROM read and the product stage set the depth of the pipe.
// Reset clears the stage valid bits and sets every room bound to zero.
// Each stage holds only while the stage after it is full and stalled, so shape.ready
// drops only when all four stages hold words and result.ready is low.
module box_containment_test #(
  parameter int COORD_WIDTH = 24,
  parameter int ANGLE_BITS  = 12,
  parameter int TRIG_WIDTH  = 16
) (
  input  logic         clk,
  input  logic         rst,
  bct_cfg_if.sink      cfg,
  bct_shape_if.sink    shape,
  bct_result_if.source result
);
  import bct_pkg::*;

  logic signed [COORD_WIDTH-1:0] room_lo [AXES];
  logic signed [COORD_WIDTH-1:0] room_hi [AXES];

  stage_en_t en;
  logic      va;
  logic      vb;
  logic      vc;
  logic      vd;

  mode_t                         mode_a;
  logic signed [COORD_WIDTH-1:0] center_a [AXES];
  logic signed [COORD_WIDTH-1:0] center_b [AXES];
  logic signed [COORD_WIDTH-1:0] center_c [AXES];
  logic        [COORD_WIDTH-2:0] half_x_a;
  logic        [COORD_WIDTH-2:0] half_y_a;
  logic        [COORD_WIDTH-2:0] half_z_a;

  logic                  quad_odd;
  logic [TRIG_WIDTH-1:0] sin_i;
  logic [TRIG_WIDTH-1:0] sin_qi;

  logic [COORD_WIDTH:0] ext_c [AXES];
  logic                 known_c;
  logic                 inside_c;
  logic                 inside_d;

  // advance a stage when the next one is empty or advancing
  assign en.d = !vd || result.ready;
  assign en.c = !vc || en.d;
  assign en.b = !vb || en.c;
  assign en.a = !va || en.b;

  assign shape.ready       = en.a;
  assign result.valid      = vd;
  assign result.inside_res = inside_d;

  bct_cfg_regs #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .room_lo (room_lo),
    .room_hi (room_hi)
  );

  bct_trig_rom #(
    .ANGLE_BITS (ANGLE_BITS),
    .TRIG_WIDTH (TRIG_WIDTH)
  ) u_rom (
    .clk      (clk),
    .en       (en.a),
    .angle    (shape.yaw_angle),
    .quad_odd (quad_odd),
    .sin_i    (sin_i),
    .sin_qi   (sin_qi)
  );

  bct_extent #(
    .COORD_WIDTH (COORD_WIDTH),
    .TRIG_WIDTH  (TRIG_WIDTH)
  ) u_extent (
    .clk      (clk),
    .en       (en),
    .mode     (mode_a),
    .half_x   (half_x_a),
    .half_y   (half_y_a),
    .half_z   (half_z_a),
    .quad_odd (quad_odd),
    .sin_i    (sin_i),
    .sin_qi   (sin_qi),
    .ext      (ext_c),
    .known    (known_c)
  );

  bct_span_check #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_check (
    .center  (center_c),
    .ext     (ext_c),
    .room_lo (room_lo),
    .room_hi (room_hi),
    .known   (known_c),
    .fits    (inside_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (en.a) begin
        va <= shape.valid;
      end
      if (en.b) begin
        vb <= va;
      end
      if (en.c) begin
        vc <= vb;
      end
      if (en.d) begin
        vd <= vc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.a) begin
      mode_a           <= shape.mode;
      center_a[AXIS_X] <= shape.center_x;
      center_a[AXIS_Y] <= shape.center_y;
      center_a[AXIS_Z] <= shape.center_z;
      half_x_a         <= shape.half_x;
      half_y_a         <= shape.half_y;
      half_z_a         <= shape.half_z;
    end
    if (en.b) begin
      center_b <= center_a;
    end
    if (en.c) begin
      center_c <= center_b;
    end
    if (en.d) begin
      inside_d <= inside_c;
    end
  end

endmodule

>>> sim/box_containment_test_test.sv
// Self-checking testbench for the room box containment test block.
module box_containment_test_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bct_pkg::*;

  localparam int COORD_W = 24;
  localparam int ANGLE_W = 12;
  localparam int TRIG_W  = 16;

  localparam int FRAC    = TRIG_W - 1;
  localparam int QBITS   = ANGLE_W - 2;
  localparam int QUARTER = 1 << QBITS;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint HALF_MAX  = (64'sd1 <<< (COORD_W - 1)) - 1;

  // indexes with no register behind them
  localparam cfg_index_t REG_UNUSED_LO = 3'd6;
  localparam cfg_index_t REG_UNUSED_HI = 3'd7;

  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned SETTLE       = 10;

  typedef struct packed {
    mode_t                     mode;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic        [COORD_W-2:0] half_x;
    logic        [COORD_W-2:0] half_y;
    logic        [COORD_W-2:0] half_z;
    logic        [ANGLE_W-1:0] yaw_angle;
  } shape_word_t;

  typedef longint axis_vals_t [AXES];

  typedef enum {
    ROOM_MODERATE,
    ROOM_FULL,
    ROOM_EMPTY,
    ROOM_TIGHT,
    ROOM_WILD,
    ROOM_ZERO
  } room_kind_e;

  class containment_scoreboard;
    longint          bound_lo [AXES];
    longint          bound_hi [AXES];
    longint unsigned sine_rom [QUARTER+1];
    bit              pending_verdicts [$];
    int unsigned     errors;

    function new();
      errors = 0;
      for (int a = 0; a < AXES; a++) begin
        bound_lo[a] = 0;
        bound_hi[a] = 0;
      end
      for (int k = 0; k <= QUARTER; k++) sine_rom[k] = quarter_sine(k);
    endfunction

    // sin(k * pi / (2 * QUARTER)) in Q1.FRAC, from a Q30 Taylor sum
    function longint unsigned quarter_sine(int unsigned k);
      longint unsigned kk, x, x2, term, s;
      longint acc;
      kk = k;
      x = (kk * HALF_PI_Q30 + (QUARTER / 2)) >> QBITS;
      x2 = (x * x + (ONE_Q30 >> 1)) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        term = (term * x2 + (ONE_Q30 >> 1)) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
      s = (longint'(acc) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      if (s > (64'd1 << FRAC)) s = 64'd1 << FRAC;
      return s;
    endfunction

    function void extents(shape_word_t w, output longint ex, output longint ey,
                          output longint ez);
      longint unsigned hx, hz, sin_mag, cos_mag, lo_tab, hi_tab, rnd;
      logic [1:0] quad;
      int unsigned idx;
      hx = w.half_x;
      hz = w.half_z;
      ex = 0;
      ey = 0;
      ez = 0;
      if (w.mode == MODE_SPHERE) begin
        ex = longint'(hx);
        ey = longint'(hx);
        ez = longint'(hx);
      end else if (w.mode == MODE_BOX) begin
        quad = w.yaw_angle[ANGLE_W-1 -: 2];
        idx = w.yaw_angle[QBITS-1:0];
        lo_tab = sine_rom[idx];
        hi_tab = sine_rom[QUARTER - idx];
        sin_mag = quad[0] ? hi_tab : lo_tab;
        cos_mag = quad[0] ? lo_tab : hi_tab;
        rnd = 64'd1 << (FRAC - 1);
        ex = longint'((hx * cos_mag + hz * sin_mag + rnd) >> FRAC);
        ey = longint'(w.half_y);
        ez = longint'((hx * sin_mag + hz * cos_mag + rnd) >> FRAC);
      end
    endfunction

    function bit predict_inside(shape_word_t w);
      longint e [AXES];
      longint c [AXES];
      bit ok;
      if (w.mode != MODE_SPHERE && w.mode != MODE_BOX) return 1'b0;
      extents(w, e[AXIS_X], e[AXIS_Y], e[AXIS_Z]);
      c[AXIS_X] = w.center_x;
      c[AXIS_Y] = w.center_y;
      c[AXIS_Z] = w.center_z;
      ok = 1'b1;
      for (int a = 0; a < AXES; a++)
        if (c[a] - e[a] < bound_lo[a] || c[a] + e[a] > bound_hi[a]) ok = 1'b0;
      return ok;
    endfunction

    function void write_bound(cfg_index_t idx, logic [COORD_W-1:0] data);
      longint v;
      v = $signed(data);
      case (idx)
        REG_MIN_X: bound_lo[AXIS_X] = v;
        REG_MAX_X: bound_hi[AXIS_X] = v;
        REG_MIN_Y: bound_lo[AXIS_Y] = v;
        REG_MAX_Y: bound_hi[AXIS_Y] = v;
        REG_MIN_Z: bound_lo[AXIS_Z] = v;
        REG_MAX_Z: bound_hi[AXIS_Z] = v;
        default: ;
      endcase
    endfunction

    function void add_shape(shape_word_t w);
      pending_verdicts = {pending_verdicts, predict_inside(w)};
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict word, expected none, got %0b", $time, got);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got !== want) begin
        $display("%0t: inside_res mismatch, expected %0b, got %0b", $time, want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_verdicts.size();
    endfunction

    function void report_leftover();
      if (pending_verdicts.size() != 0) begin
        $display("%0t: verdicts missing, expected %0d more, got 0", $time,
                 pending_verdicts.size());
        errors += pending_verdicts.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  bct_cfg_if   #(.COORD_WIDTH(COORD_W))                      cfg_ch ();
  bct_shape_if #(.COORD_WIDTH(COORD_W), .ANGLE_BITS(ANGLE_W)) shape_ch ();
  bct_result_if                                               result_ch ();

  box_containment_test #(
    .COORD_WIDTH(COORD_W),
    .ANGLE_BITS (ANGLE_W),
    .TRIG_WIDTH (TRIG_W)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .shape (shape_ch),
    .result(result_ch)
  );

  containment_scoreboard sb = new();

  axis_vals_t  room_lo;
  axis_vals_t  room_hi;
  int unsigned tx_max = 15;
  int unsigned rx_max = 15;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint rand_between(longint a, longint b);
    longint t;
    longint unsigned r;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    r = {$urandom, $urandom};
    return a + longint'(r % longint'(b - a + 1));
  endfunction

  // skew toward small values while still reaching the cap
  function automatic longint rand_upto(longint cap);
    if (cap <= 0) return 0;
    return longint'($urandom_range(0, int'(cap)) >> $urandom_range(0, 12));
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic shape_word_t mk(mode_t mode, longint cx, longint cy, longint cz,
                                     longint hx, longint hy, longint hz, longint yaw);
    shape_word_t w;
    w.mode      = mode;
    w.center_x  = cx[COORD_W-1:0];
    w.center_y  = cy[COORD_W-1:0];
    w.center_z  = cz[COORD_W-1:0];
    w.half_x    = hx[COORD_W-2:0];
    w.half_y    = hy[COORD_W-2:0];
    w.half_z    = hz[COORD_W-2:0];
    w.yaw_angle = yaw[ANGLE_W-1:0];
    return w;
  endfunction

  function automatic void make_room(room_kind_e kind);
    longint c, s, t;
    int unsigned k;
    for (int a = 0; a < AXES; a++) begin
      case (kind)
        ROOM_FULL: begin
          room_lo[a] = COORD_MIN;
          room_hi[a] = COORD_MAX;
        end
        ROOM_TIGHT: begin
          c = rand_between(-100, 100);
          s = $urandom_range(0, 64);
          room_lo[a] = c - s;
          room_hi[a] = c + s;
        end
        ROOM_WILD: begin
          room_lo[a] = $signed(COORD_W'($urandom));
          room_hi[a] = $signed(COORD_W'($urandom));
        end
        ROOM_ZERO: begin
          room_lo[a] = 0;
          room_hi[a] = 0;
        end
        default: begin
          c = rand_between(-(64'sd1 <<< 22), 64'sd1 <<< 22);
          s = rand_upto(64'sd1 <<< 20);
          room_lo[a] = c - s;
          room_hi[a] = c + s;
        end
      endcase
    end
    if (kind == ROOM_EMPTY) begin
      // invert one axis so its minimum sits above its maximum
      k = $urandom_range(0, AXES - 1);
      t = room_lo[k];
      room_lo[k] = room_hi[k] + 1;
      room_hi[k] = t;
    end
  endfunction

  function automatic shape_word_t make_shape();
    shape_word_t w;
    longint e [AXES];
    longint smin, hcap, a, b, c;
    int unsigned pick, shift;
    pick = $urandom_range(0, 9);
    w = shape_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(0, 9))
      0:             w.mode = mode_t'($urandom_range(2, 3));
      1, 2, 3, 4:    w.mode = MODE_SPHERE;
      default:       w.mode = MODE_BOX;
    endcase
    if ($urandom_range(0, 3) == 0) w.yaw_angle = {2'($urandom_range(0, 3)), QBITS'(0)};
    if (pick >= 7) begin
      shift = $urandom_range(0, 1) ? 0 : $urandom_range(0, COORD_W - 2);
      w.half_x = w.half_x >> shift;
      w.half_z = w.half_z >> shift;
      return w;
    end
    smin = HALF_MAX;
    for (int k = 0; k < AXES; k++)
      if (room_hi[k] - room_lo[k] < smin) smin = room_hi[k] - room_lo[k];
    hcap = (smin < 0) ? 0 : smin / 2;
    if (hcap > HALF_MAX) hcap = HALF_MAX;
    w.half_x = (COORD_W-1)'(rand_upto(hcap));
    if (w.mode == MODE_BOX) begin
      w.half_y = (COORD_W-1)'(rand_upto(hcap));
      w.half_z = (COORD_W-1)'(rand_upto(hcap * 3 / 4));
      w.half_x = (COORD_W-1)'(rand_upto(hcap * 3 / 4));
    end
    sb.extents(w, e[AXIS_X], e[AXIS_Y], e[AXIS_Z]);
    for (int k = 0; k < AXES; k++) begin
      a = room_lo[k] + e[k];
      b = room_hi[k] - e[k];
      if ($urandom_range(0, 3) == 0)
        c = ($urandom_range(0, 1) ? a : b) + longint'($urandom_range(0, 2)) - 1;
      else if (a <= b)
        c = rand_between(a, b);
      else
        c = rand_between(room_lo[k], room_hi[k]);
      c = clamp_coord(c);
      case (k)
        AXIS_X:  w.center_x = c[COORD_W-1:0];
        AXIS_Y:  w.center_y = c[COORD_W-1:0];
        default: w.center_z = c[COORD_W-1:0];
      endcase
    end
    return w;
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_shape(input shape_word_t w);
    int unsigned gap;
    gap = $urandom_range(0, tx_max);
    if (gap != 0) begin
      shape_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    shape_ch.mode      = w.mode;
    shape_ch.center_x  = w.center_x;
    shape_ch.center_y  = w.center_y;
    shape_ch.center_z  = w.center_z;
    shape_ch.half_x    = w.half_x;
    shape_ch.half_y    = w.half_y;
    shape_ch.half_z    = w.half_z;
    shape_ch.yaw_angle = w.yaw_angle;
    shape_ch.valid     = 1'b1;
    do @(posedge clk); while (!shape_ch.ready);
    @(negedge clk);
    sb.add_shape(w);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [COORD_W-1:0] data);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    sb.write_bound(idx, data);
  endtask

  task automatic set_room();
    write_reg(REG_MIN_X, room_lo[AXIS_X][COORD_W-1:0]);
    write_reg(REG_MAX_X, room_hi[AXIS_X][COORD_W-1:0]);
    write_reg(REG_MIN_Y, room_lo[AXIS_Y][COORD_W-1:0]);
    write_reg(REG_MAX_Y, room_hi[AXIS_Y][COORD_W-1:0]);
    write_reg(REG_MIN_Z, room_lo[AXIS_Z][COORD_W-1:0]);
    write_reg(REG_MAX_Z, room_hi[AXIS_Z][COORD_W-1:0]);
    // must not disturb any bound
    write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, COORD_W'($urandom));
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    int unsigned cycles;
    shape_ch.valid = 1'b0;
    cycles = 0;
    while (sb.pending() != 0 && cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      cycles++;
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic uniform_room(input longint lo, input longint hi);
    for (int a = 0; a < AXES; a++) begin
      room_lo[a] = lo;
      room_hi[a] = hi;
    end
  endtask

  // verdict sink: random back-pressure plus one long hold-off
  initial begin : verdict_sink
    int unsigned gap;
    int unsigned taken;
    bit held;
    taken = 0;
    held = 1'b0;
    result_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!held && taken == HOLD_AT) begin
        held = 1'b1;
        result_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = $urandom_range(0, rx_max);
      if (gap != 0) begin
        result_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      sb.check_verdict(result_ch.inside_res);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    room_kind_e plan [PHASES] = '{ROOM_MODERATE, ROOM_FULL, ROOM_MODERATE, ROOM_EMPTY,
                                  ROOM_TIGHT, ROOM_WILD, ROOM_ZERO, ROOM_MODERATE};
    rst = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_MIN_X;
    cfg_ch.data        = '0;
    shape_ch.valid     = 1'b0;
    shape_ch.mode      = MODE_SPHERE;
    shape_ch.center_x  = '0;
    shape_ch.center_y  = '0;
    shape_ch.center_z  = '0;
    shape_ch.half_x    = '0;
    shape_ch.half_y    = '0;
    shape_ch.half_z    = '0;
    shape_ch.yaw_angle = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset room: only a zero-size shape at the origin fits
    send_shape(mk(MODE_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    send_shape(mk(MODE_SPHERE, 0, 0, 0, 1, 0, 0, 0));
    send_shape(mk(MODE_SPHERE, 1, 0, 0, 0, 0, 0, 0));
    send_shape(mk(MODE_BOX, 0, 0, 0, 0, 0, 0, 4095));
    send_shape(mk(mode_t'(2), 0, 0, 0, 0, 0, 0, 0));
    send_shape(mk(mode_t'(3), 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // widest room, extreme coordinates and extents
    uniform_room(COORD_MIN, COORD_MAX);
    set_room();
    send_shape(mk(MODE_SPHERE, 0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX, 4095));
    send_shape(mk(MODE_SPHERE, COORD_MAX, 0, 0, 1, 0, 0, 0));
    send_shape(mk(MODE_SPHERE, COORD_MIN, COORD_MAX, COORD_MIN, 0, 0, 0, 0));
    send_shape(mk(MODE_BOX, 0, 0, 0, 0, HALF_MAX, HALF_MAX, 0));
    send_shape(mk(MODE_BOX, 0, 0, 0, HALF_MAX, 0, HALF_MAX, 512));
    send_shape(mk(MODE_BOX, 0, 0, 0, HALF_MAX, 0, 0, 1024));
    send_shape(mk(MODE_BOX, -1, 0, 0, HALF_MAX, 0, 0, 2048));
    send_shape(mk(MODE_BOX, 1, 0, 0, HALF_MAX, 0, 0, 2048));
    send_shape(mk(MODE_BOX, 0, COORD_MAX, 0, 12345, 0, 777, 3072));
    send_shape(mk(MODE_BOX, 0, 0, 0, 400000, 1, 300000, 4095));
    send_shape(mk(mode_t'(3), COORD_MAX, COORD_MAX, COORD_MAX, HALF_MAX, HALF_MAX,
                  HALF_MAX, 4095));
    wait_idle();

    // minimum above maximum on x: nothing fits
    uniform_room(COORD_MIN, COORD_MAX);
    room_lo[AXIS_X] = 100;
    room_hi[AXIS_X] = -100;
    set_room();
    send_shape(mk(MODE_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    send_shape(mk(MODE_BOX, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // small room, rotated boxes near the walls
    uniform_room(-1000, 1000);
    set_room();
    send_shape(mk(MODE_BOX, 0, 0, 0, 500, 500, 500, 512));
    send_shape(mk(MODE_BOX, 300, 0, 0, 500, 500, 500, 512));
    send_shape(mk(MODE_SPHERE, 0, 0, 0, 1000, 0, 0, 0));
    send_shape(mk(MODE_SPHERE, 0, 1, 0, 1000, 0, 0, 0));
    send_shape(mk(MODE_BOX, 0, 0, 0, 1000, 1000, 0, 1536));
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      make_room(plan[p]);
      set_room();
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      repeat (PHASE_ITEMS) send_shape(make_shape());
      wait_idle();
    end

    sb.report_leftover();
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
